// ===== src/bounded_byte_stream_fifo_core_macros.svh =====
// Assertion macros for the bounded byte stream FIFO core.
// Expects clk and arst_n in the scope of each use.
`ifndef BOUNDED_BYTE_STREAM_FIFO_CORE_MACROS_SVH
`define BOUNDED_BYTE_STREAM_FIFO_CORE_MACROS_SVH

// same-cycle implication
`define BBSF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BBSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bbsf_pkg.sv =====
// Shared types and constants for the bounded byte stream FIFO core.
// No dependencies; imported by the front, back and top modules and the testbench.
package bbsf_pkg;

	localparam int OP_W    = 3;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 11;
	localparam int TOTAL_W = 32;

	localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
	localparam logic [OP_W-1:0] OP_READ   = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
	localparam logic [OP_W-1:0] OP_POP    = 3'd3;
	localparam logic [OP_W-1:0] OP_END    = 3'd4;
	localparam logic [OP_W-1:0] OP_STATUS = 3'd5;

	localparam logic [CNT_W-1:0] CAPACITY_RESET = 11'd1024;

	localparam int CMD_QDEPTH = 2;
	localparam int RES_QDEPTH = 4;

	typedef enum logic [5:0] {
		KIND_WRITE  = 6'b000001,
		KIND_READ   = 6'b000010,
		KIND_PEEK   = 6'b000100,
		KIND_POP    = 6'b001000,
		KIND_END    = 6'b010000,
		KIND_STATUS = 6'b100000
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data_byte;
		logic [CNT_W-1:0]  count;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic               byte_valid;
		logic               accepted;
		logic [CNT_W-1:0]   fill_level;
		logic [CNT_W-1:0]   room_left;
		logic               input_closed;
		logic               stream_done;
		logic [TOTAL_W-1:0] total_written;
		logic [TOTAL_W-1:0] total_read;
	} res_t;

endpackage

// ===== src/bbsf_queue.sv =====
// Small register queue used between the front and back and for results.
// Depends on nothing; a push while full and a pop while empty are ignored.
module bbsf_queue #(
	parameter int W      = 8,
	parameter int QDEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 din,
	input  logic                         pop,
	output logic [W-1:0]                 dout,
	output logic                         empty,
	output logic                         full,
	output logic [$clog2(QDEPTH+1)-1:0]  level
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int LW = $clog2(QDEPTH+1);

	logic [W-1:0]  slot_q [QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [LW-1:0] level_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (level_q == '0);
	assign full    = (level_q == LW'(QDEPTH));
	assign level   = level_q;
	assign dout    = slot_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(QDEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(QDEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= din;
		end
	end

endmodule

// ===== src/bbsf_front.sv =====
// Front end: takes requests, classifies the operation code and queues commands.
// Depends on bbsf_pkg and bbsf_queue.
module bbsf_front import bbsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [OP_W-1:0]   operation,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [CNT_W-1:0]  count,
	output logic              cmd_valid,
	input  logic              cmd_take,
	output cmd_t              cmd
);

	cmd_t                          cmd_d;
	logic [$bits(cmd_t)-1:0]       cmd_raw;
	logic                          cmd_empty;
	logic [$clog2(CMD_QDEPTH+1)-1:0] cmd_level;

	always_comb begin
		cmd_d.data_byte = data_byte;
		cmd_d.count     = count;
		case (operation)
			OP_WRITE: cmd_d.kind = KIND_WRITE;
			OP_READ:  cmd_d.kind = KIND_READ;
			OP_PEEK:  cmd_d.kind = KIND_PEEK;
			OP_POP:   cmd_d.kind = KIND_POP;
			OP_END:   cmd_d.kind = KIND_END;
			default:  cmd_d.kind = KIND_STATUS;
		endcase
	end

	bbsf_queue #(
		.W      ($bits(cmd_t)),
		.QDEPTH (CMD_QDEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_d),
		.pop    (cmd_take),
		.dout   (cmd_raw),
		.empty  (cmd_empty),
		.full   (full),
		.level  (cmd_level)
	);

	assign cmd       = cmd_t'(cmd_raw);
	assign cmd_valid = !cmd_empty && (cmd_level != '0);

endmodule

// ===== src/bbsf_back.sv =====
// Back end: executes commands against the byte store, keeps pointers and totals,
// and queues one result per command. Depends on bbsf_pkg and bbsf_queue.
module bbsf_back import bbsf_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] capacity,
	input  logic             cmd_valid,
	output logic             cmd_take,
	input  cmd_t             cmd,
	output res_t             res,
	output logic             res_empty,
	input  logic             res_pop
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam int WW = (CW > CNT_W) ? CW : CNT_W;
	localparam int SW = WW + 1;
	localparam int RLW = $clog2(RES_QDEPTH+1);

	logic [BYTE_W-1:0] mem_q [DEPTH];

	logic [AW-1:0]      head_q;
	logic [CW-1:0]      held_q;
	logic [TOTAL_W-1:0] wtot_q;
	logic [TOTAL_W-1:0] rtot_q;
	logic               closed_q;

	logic [AW-1:0]      head_n;
	logic [CW-1:0]      held_n;
	logic [TOTAL_W-1:0] wtot_n;
	logic [TOTAL_W-1:0] rtot_n;
	logic               closed_n;

	logic               valid_s2;
	logic               bv_s2;
	logic               acc_s2;
	logic [CW-1:0]      fill_s2;
	logic               closed_s2;
	logic [TOTAL_W-1:0] wtot_s2;
	logic [TOTAL_W-1:0] rtot_s2;
	logic [BYTE_W-1:0]  rdata_s2;

	logic [WW-1:0] cap_w;
	logic [WW-1:0] held_w;
	logic [WW-1:0] cnt_w;
	logic [WW-1:0] n_pop;
	logic [WW-1:0] off;
	logic [SW-1:0] sum;
	logic [AW-1:0] slot;
	logic [AW-1:0] raddr;
	logic          issue;
	logic          we;
	logic          re;
	logic          acc;
	logic          bv;

	logic [WW-1:0]            fill_w;
	logic [WW-1:0]            room_w;
	res_t                     res_d;
	logic [$bits(res_t)-1:0]  res_raw;
	logic                     res_full;
	logic [RLW-1:0]           res_level;

	assign cap_w  = (WW'(capacity) > WW'(DEPTH)) ? WW'(DEPTH) : WW'(capacity);
	assign held_w = WW'(held_q);
	assign cnt_w  = WW'(cmd.count);
	assign n_pop  = (cnt_w < held_w) ? cnt_w : held_w;

	assign issue    = cmd_valid &&
		((RLW+1)'(res_level) + (RLW+1)'(valid_s2) < (RLW+1)'(RES_QDEPTH));
	assign cmd_take = issue;

	always_comb begin
		case (cmd.kind)
			KIND_WRITE: off = held_w;
			KIND_READ:  off = WW'(1);
			KIND_PEEK:  off = cnt_w;
			KIND_POP:   off = n_pop;
			default:    off = '0;
		endcase
	end

	always_comb begin
		sum = SW'(head_q) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		slot = sum[AW-1:0];
	end

	always_comb begin
		head_n   = head_q;
		held_n   = held_q;
		wtot_n   = wtot_q;
		rtot_n   = rtot_q;
		closed_n = closed_q;
		we       = 1'b0;
		re       = 1'b0;
		raddr    = slot;
		acc      = 1'b0;
		bv       = 1'b0;
		if (issue) begin
			case (cmd.kind)
				KIND_WRITE: begin
					if (!closed_q && held_w < cap_w) begin
						we     = 1'b1;
						acc    = 1'b1;
						held_n = held_q + 1'b1;
						wtot_n = wtot_q + 1'b1;
					end
				end
				KIND_READ: begin
					if (held_q != '0) begin
						re     = 1'b1;
						bv     = 1'b1;
						raddr  = head_q;
						head_n = slot;
						held_n = held_q - 1'b1;
						rtot_n = rtot_q + 1'b1;
					end
				end
				KIND_PEEK: begin
					if (cnt_w < held_w) begin
						re = 1'b1;
						bv = 1'b1;
					end
				end
				KIND_POP: begin
					head_n = slot;
					held_n = held_q - n_pop[CW-1:0];
					rtot_n = rtot_q + TOTAL_W'(n_pop);
				end
				KIND_END: begin
					closed_n = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			held_q   <= '0;
			wtot_q   <= '0;
			rtot_q   <= '0;
			closed_q <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			head_q   <= head_n;
			held_q   <= held_n;
			wtot_q   <= wtot_n;
			rtot_q   <= rtot_n;
			closed_q <= closed_n;
			valid_s2 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			bv_s2     <= bv;
			acc_s2    <= acc;
			fill_s2   <= held_n;
			closed_s2 <= closed_n;
			wtot_s2   <= wtot_n;
			rtot_s2   <= rtot_n;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[slot] <= cmd.data_byte;
		end
		if (re) begin
			rdata_s2 <= mem_q[raddr];
		end
	end

	assign fill_w = WW'(fill_s2);
	assign room_w = (cap_w > fill_w) ? cap_w - fill_w : '0;

	always_comb begin
		res_d.out_byte      = bv_s2 ? rdata_s2 : '0;
		res_d.byte_valid    = bv_s2;
		res_d.accepted      = acc_s2;
		res_d.fill_level    = fill_w[CNT_W-1:0];
		res_d.room_left     = room_w[CNT_W-1:0];
		res_d.input_closed  = closed_s2;
		res_d.stream_done   = closed_s2 && (fill_s2 == '0);
		res_d.total_written = wtot_s2;
		res_d.total_read    = rtot_s2;
	end

	bbsf_queue #(
		.W      ($bits(res_t)),
		.QDEPTH (RES_QDEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_s2),
		.din    (res_d),
		.pop    (res_pop),
		.dout   (res_raw),
		.empty  (res_empty),
		.full   (res_full),
		.level  (res_level)
	);

	assign res = res_full ? res_t'(res_raw) : res_t'(res_raw);

endmodule

// ===== src/bounded_byte_stream_fifo_core.sv =====
// Bounded byte stream FIFO core: queue-style request and result ports, APB capacity register.
// Each request passes the command queue, the execute stage registers and the result queue.
// Throughput: one request per cycle while the result queue has room, set by the execute stage.
// Reset clears pointers, fill, totals and the closed flag; capacity returns to 1024.
// The byte store is not cleared; only entries holding data are ever read.
// Depends on bbsf_pkg, bbsf_front, bbsf_back and the assertion macro header.
`include "bounded_byte_stream_fifo_core_macros.svh"
module bounded_byte_stream_fifo_core import bbsf_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [OP_W-1:0]    operation,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic [CNT_W-1:0]   count,
	output logic               empty,
	input  logic               pop,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               byte_valid,
	output logic               accepted,
	output logic [CNT_W-1:0]   fill_level,
	output logic [CNT_W-1:0]   room_left,
	output logic               input_closed,
	output logic               stream_done,
	output logic [TOTAL_W-1:0] total_written,
	output logic [TOTAL_W-1:0] total_read,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [CNT_W-1:0] capacity_q;
	logic             cfg_wr;
	logic             cmd_valid;
	logic             cmd_take;
	cmd_t             cmd;
	res_t             res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? 32'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wr) begin
			capacity_q <= pwdata[CNT_W-1:0];
		end
	end

	bbsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.data_byte (data_byte),
		.count     (count),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	bbsf_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign out_byte      = res.out_byte;
	assign byte_valid    = res.byte_valid;
	assign accepted      = res.accepted;
	assign fill_level    = res.fill_level;
	assign room_left     = res.room_left;
	assign input_closed  = res.input_closed;
	assign stream_done   = res.stream_done;
	assign total_written = res.total_written;
	assign total_read    = res.total_read;

	`BBSF_ASSERT_NOW(a_no_byte_on_write, !empty, !(accepted && byte_valid), "write result carries a byte")
	`BBSF_ASSERT_NOW(a_zero_byte_when_invalid, !empty && !byte_valid, out_byte == '0, "stale byte on result")
	`BBSF_ASSERT_NOW(a_done_needs_closed, !empty && !input_closed, !stream_done, "done while input open")
	`BBSF_ASSERT_NEXT(a_closed_sticky, !empty && input_closed && pop, empty || input_closed, "closed flag reopened")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for bounded_byte_stream_fifo_core: queue-style request and result
// handshakes, APB capacity writes, scoreboard class that predicts each result in order.
// Depends on bbsf_pkg and the RTL under src.
`timescale 1ns / 100ps
module testbench;
	import bbsf_pkg::*;

	localparam int FIFO_DEPTH = 1024;
	localparam int LONG_HOLD = 400;
	localparam int LIMIT_NS = 4_000_000;
	localparam logic [2:0] CAPACITY_ADDR = 3'd0;
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	class byte_fifo_scoreboard;
		logic [BYTE_W-1:0] bytes [FIFO_DEPTH];
		int unsigned head;
		int unsigned held;
		int unsigned capacity;
		logic [TOTAL_W-1:0] wr_total;
		logic [TOTAL_W-1:0] rd_total;
		bit closed;
		res_t owed[$];
		int unsigned mismatches;

		function new();
			head = 0;
			held = 0;
			capacity = CAPACITY_RESET;
			wr_total = '0;
			rd_total = '0;
			closed = 0;
			mismatches = 0;
		endfunction

		function int unsigned pending();
			return owed.size();
		endfunction

		function void set_capacity(logic [CNT_W-1:0] value);
			capacity = value;
		endfunction

		function void note_mismatch(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH at %0t: %s", $realtime, what);
		endfunction

		function string fields(res_t r);
			return $sformatf("byte %h valid %b acc %b fill %0d room %0d closed %b done %b wr %0d rd %0d",
				r.out_byte, r.byte_valid, r.accepted, r.fill_level, r.room_left,
				r.input_closed, r.stream_done, r.total_written, r.total_read);
		endfunction

		function void discard(int unsigned n);
			head = (head + n) % FIFO_DEPTH;
			held -= n;
			rd_total += TOTAL_W'(n);
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] din,
				logic [CNT_W-1:0] cnt);
			res_t r;
			int unsigned lim;
			r = '0;
			lim = (capacity > FIFO_DEPTH) ? FIFO_DEPTH : capacity;
			case (op)
				OP_WRITE: begin
					if (!closed && held < lim) begin
						bytes[(head + held) % FIFO_DEPTH] = din;
						held++;
						wr_total++;
						r.accepted = 1'b1;
					end
				end
				OP_READ: begin
					if (held > 0) begin
						r.out_byte = bytes[head];
						r.byte_valid = 1'b1;
						discard(1);
					end
				end
				OP_PEEK: begin
					if (cnt < held) begin
						r.out_byte = bytes[(head + cnt) % FIFO_DEPTH];
						r.byte_valid = 1'b1;
					end
				end
				OP_POP: discard((cnt < held) ? cnt : held);
				OP_END: closed = 1;
				default: ;
			endcase
			r.fill_level = CNT_W'(held);
			r.room_left = CNT_W'((lim > held) ? lim - held : 0);
			r.input_closed = closed;
			r.stream_done = closed && held == 0;
			r.total_written = wr_total;
			r.total_read = rd_total;
			owed = {owed, r};
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (owed.size() == 0) begin
				note_mismatch({"result with nothing outstanding: ", fields(got)});
				return;
			end
			want = owed[0];
			owed.delete(0);
			if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
					got.accepted !== want.accepted || got.fill_level !== want.fill_level ||
					got.room_left !== want.room_left || got.input_closed !== want.input_closed ||
					got.stream_done !== want.stream_done ||
					got.total_written !== want.total_written ||
					got.total_read !== want.total_read) begin
				note_mismatch({"expected ", fields(want), " got ", fields(got)});
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [OP_W-1:0]    operation;
	logic [BYTE_W-1:0]  data_byte;
	logic [CNT_W-1:0]   count;
	logic               empty;
	logic               pop;
	logic [BYTE_W-1:0]  out_byte;
	logic               byte_valid;
	logic               accepted;
	logic [CNT_W-1:0]   fill_level;
	logic [CNT_W-1:0]   room_left;
	logic               input_closed;
	logic               stream_done;
	logic [TOTAL_W-1:0] total_written;
	logic [TOTAL_W-1:0] total_read;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	byte_fifo_scoreboard sb;
	int burst_left = 0;
	int unsigned holds_asked = 0;

	bounded_byte_stream_fifo_core #(.DEPTH(FIFO_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.data_byte(data_byte),
		.count(count),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.accepted(accepted),
		.fill_level(fill_level),
		.room_left(room_left),
		.input_closed(input_closed),
		.stream_done(stream_done),
		.total_written(total_written),
		.total_read(total_read),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("testbench NOT OK");
		$finish;
	end

	task automatic offer(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
			input logic [CNT_W-1:0] cnt);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		operation <= op;
		data_byte <= din;
		count <= cnt;
		do @(posedge clk); while (full !== 1'b0);
		sb.note_request(op, din, cnt);
	endtask

	task automatic offer_random(input int write_pct, input bit allow_end);
		logic [OP_W-1:0] op;
		logic [CNT_W-1:0] cnt;
		cnt = CNT_W'($urandom_range(0, 2047));
		if ($urandom_range(0, 99) < write_pct) begin
			op = OP_WRITE;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: op = OP_READ;
				3, 4: begin
					op = OP_PEEK;
					if ($urandom_range(0, 4) != 0)
						cnt = CNT_W'($urandom_range(0, sb.held + 1));
				end
				5, 6: begin
					op = OP_POP;
					if ($urandom_range(0, 5) != 0)
						cnt = CNT_W'($urandom_range(0, 3));
				end
				7: op = OP_STATUS;
				8: op = allow_end ? OP_END : OP_READ;
				default: op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
			endcase
		end
		offer(op, BYTE_W'($urandom_range(0, 255)), cnt);
	endtask

	// hold the request side until every result is back
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= {{(32 - CNT_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_capacity(value);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[CNT_W-1:0] !== value)
			sb.note_mismatch($sformatf("capacity read %0d, wrote %0d", prdata[CNT_W-1:0], value));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] cap, input int items, input int write_pct);
		settle();
		write_capacity(cap);
		for (int i = 0; i < items; i++)
			offer_random(write_pct, 1'b0);
	endtask

	initial begin : result_side
		res_t got;
		logic [15:0] stall_pattern;
		int unsigned slot;
		int hold_left;
		int unsigned holds_served;
		pop = 1'b0;
		stall_pattern = '1;
		slot = 0;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (pop === 1'b1 && empty === 1'b0) begin
				got.out_byte = out_byte;
				got.byte_valid = byte_valid;
				got.accepted = accepted;
				got.fill_level = fill_level;
				got.room_left = room_left;
				got.input_closed = input_closed;
				got.stream_done = stream_done;
				got.total_written = total_written;
				got.total_read = total_read;
				sb.check_result(got);
			end
			if (holds_served != holds_asked) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if (slot == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pattern = '1;
						1: stall_pattern = 16'($urandom);
						2: stall_pattern = 16'($urandom | $urandom);
						default: stall_pattern = 16'($urandom & $urandom);
					endcase
				end
				pop <= stall_pattern[slot];
				slot = (slot + 1) % 16;
			end
		end
	end

	initial begin : request_side
		int extra;
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		operation = OP_STATUS;
		data_byte = '0;
		count = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = CAPACITY_ADDR;
		pwdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, spare codes, small capacity filled and overrun
		write_capacity(11'd3);
		offer(OP_READ, 8'h00, 11'd0);
		offer(OP_PEEK, 8'h00, 11'd0);
		offer(OP_POP, 8'hFF, 11'd2047);
		offer(OP_SPARE_LO, 8'hFF, 11'd2047);
		offer(OP_SPARE_HI, 8'h00, 11'd0);
		offer(OP_STATUS, 8'hFF, 11'd0);
		offer(OP_WRITE, 8'h00, 11'd0);
		offer(OP_WRITE, 8'hFF, 11'd2047);
		offer(OP_WRITE, 8'h5A, 11'd0);
		offer(OP_WRITE, 8'hA5, 11'd0);
		offer(OP_PEEK, 8'h00, 11'd0);
		offer(OP_PEEK, 8'h00, 11'd2);
		offer(OP_PEEK, 8'h00, 11'd3);
		offer(OP_PEEK, 8'h00, 11'd2047);
		offer(OP_READ, 8'h00, 11'd0);
		offer(OP_POP, 8'h00, 11'd1);
		offer(OP_STATUS, 8'h00, 11'd0);
		offer(OP_POP, 8'h00, 11'd2047);
		offer(OP_READ, 8'h00, 11'd0);
		settle();
		write_capacity(11'd0);
		offer(OP_WRITE, 8'h3C, 11'd0);
		settle();
		write_capacity(11'd2047);
		offer(OP_STATUS, 8'h00, 11'd0);
		offer(OP_WRITE, 8'hC3, 11'd0);
		offer(OP_READ, 8'h00, 11'd0);

		run_phase(11'd1, 25, 45);
		run_phase(11'd16, 30, 55);
		run_phase(11'($urandom_range(0, 2047)), 30, 45);

		// fill to the full depth while the result side stalls for a long stretch
		settle();
		write_capacity(11'd2047);
		holds_asked <= holds_asked + 1;
		extra = 0;
		for (int i = 0; i < 1300 && extra < 24; i++) begin
			if (sb.held >= FIFO_DEPTH)
				extra++;
			if ($urandom_range(0, 99) < 96)
				offer(OP_WRITE, BYTE_W'($urandom_range(0, 255)),
					CNT_W'($urandom_range(0, 2047)));
			else if ($urandom_range(0, 3) != 0)
				offer(OP_PEEK, BYTE_W'($urandom_range(0, 255)),
					CNT_W'($urandom_range(0, sb.held)));
			else
				offer(OP_STATUS, BYTE_W'($urandom_range(0, 255)),
					CNT_W'($urandom_range(0, 2047)));
		end

		run_phase(11'(sb.held / 2), 30, 40);
		run_phase(11'd1025, 40, 35);
		run_phase(11'd1023, 30, 50);
		run_phase(11'd0, 15, 50);
		run_phase(11'd2, 25, 45);

		// close the input, then drain to the end of the stream
		run_phase(11'd1024, 12, 60);
		offer(OP_END, 8'h00, 11'd0);
		offer(OP_WRITE, 8'hE7, 11'd0);
		offer(OP_END, 8'hFF, 11'd2047);
		for (int i = 0; i < 40; i++)
			offer_random(10, 1'b1);
		offer(OP_POP, 8'h00, 11'd2047);
		offer(OP_STATUS, 8'h00, 11'd0);

		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/bbsf_pkg.sv
src/bbsf_queue.sv
src/bbsf_front.sv
src/bbsf_back.sv
src/bounded_byte_stream_fifo_core.sv
sim/testbench.sv
